### rtl/assert_macros.svh
// Assertion macros for the checker file of the word stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("word stack check failed");

// The consequent must hold in the cycle after the antecedent.
`define WIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("word stack check failed");

// As above, but also checked while reset is applied.
`define WIS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("word stack check failed");

`endif

### rtl/wis_pkg.sv
// Package with operation codes, status codes, field widths and the result type.
`timescale 1ns / 1ps

package wis_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 10;
  localparam int WORD_W = 64;
  localparam int IDX_W  = 10;
  localparam int STAT_W = 2;
  localparam int FILL_W = 11;

  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_SET    = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] word_out;
    logic              match_found;
    logic [IDX_W-1:0]  match_index;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill_count;
  } res_t;

endpackage

### rtl/wis_mem.sv
// Entry memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module wis_mem #(
  parameter int DEPTH      = 1024,
  parameter int WORD_WIDTH = 64,
  parameter int AW         = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [WORD_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [WORD_WIDTH-1:0] rd_data
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/wis_ctrl.sv
// Sequencer: decodes each item, keeps the fill count and walks the memory for a search.
`timescale 1ns / 1ps

module wis_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int WORD_WIDTH = 64,
  parameter int AW         = $clog2(DEPTH),
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wis_pkg::OP_W-1:0]    in_operation,
  input  logic [wis_pkg::POS_W-1:0]   in_position,
  input  logic [wis_pkg::WORD_W-1:0]  in_word_in,
  input  logic                        out_free,
  output logic                        res_load,
  output wis_pkg::res_t               res,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [WORD_WIDTH-1:0]       wr_data,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  logic [WORD_WIDTH-1:0]       rd_data
);

  localparam int WW    = wis_pkg::WORD_W;
  localparam int IW    = wis_pkg::IDX_W;
  localparam int FW    = wis_pkg::FILL_W;
  localparam int PW    = wis_pkg::POS_W;
  localparam int CMP_W = (CNT_W > PW) ? CNT_W : PW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [WORD_WIDTH-1:0] key_r, key_nxt;
  logic                  accept;
  logic                  in_range;
  logic                  is_full;
  logic                  is_last;

  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign in_range = CMP_W'(in_position) < CMP_W'(count_r);
  assign is_full  = count_r == CNT_W'(DEPTH);
  assign is_last  = (CNT_W'(ptr_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    key_nxt   = key_r;
    wr_en     = 1'b0;
    wr_addr   = AW'(count_r);
    wr_data   = in_word_in[WORD_WIDTH-1:0];
    rd_en     = 1'b0;
    rd_addr   = AW'(in_position);
    res_load  = 1'b0;
    res       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            wis_pkg::OP_PUSH: begin
              res_load = 1'b1;
              if (is_full) begin
                res.status = wis_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            wis_pkg::OP_POP: begin
              if (count_r == '0) begin
                res_load   = 1'b1;
                res.status = wis_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                rd_en     = 1'b1;
                rd_addr   = AW'(count_r - CNT_W'(1));
                state_nxt = S_READ;
              end
            end
            wis_pkg::OP_GET: begin
              if (!in_range) begin
                res_load   = 1'b1;
                res.status = wis_pkg::ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_READ;
              end
            end
            wis_pkg::OP_SET: begin
              res_load = 1'b1;
              if (!in_range) begin
                res.status = wis_pkg::ST_RANGE;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(in_position);
              end
            end
            wis_pkg::OP_SEARCH: begin
              if (count_r == '0) begin
                res_load = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                ptr_nxt   = '0;
                key_nxt   = in_word_in[WORD_WIDTH-1:0];
                state_nxt = S_SRCH;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_load     = 1'b1;
        res.word_out = WW'(rd_data);
        state_nxt    = S_IDLE;
      end
      S_SRCH: begin
        if (rd_data == key_r) begin
          res_load        = 1'b1;
          res.match_found = 1'b1;
          res.match_index = IW'(ptr_r);
          state_nxt       = S_IDLE;
        end else if (is_last) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
          rd_en   = 1'b1;
          rd_addr = ptr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res.fill_count = FW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
  end

endmodule

### rtl/indexed_word_stack_with_search_top.sv
// Top level of the indexed word stack with search: sequencer, entry memory and output register.
`timescale 1ns / 1ps

// A bounded stack of up to DEPTH words held in one single-port-read memory.
// Each item names one operation and returns one result item. Push, set,
// refused operations, unknown codes and a search of an empty stack complete in
// the cycle of acceptance; pop and get first read the memory, and their result
// is loaded from the read data in the read state. A search reads one stored
// entry per cycle from the lowest index upwards until a hit or the last entry,
// since the entry memory has a single read port.
// The result sits in an output register, so a new item is taken while the
// previous result is being collected. Entries need no clearing after reset.

module indexed_word_stack_with_search_top #(
  parameter int DEPTH      = 1024,
  parameter int WORD_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wis_pkg::OP_W-1:0]    in_operation,
  input  logic [wis_pkg::POS_W-1:0]   in_position,
  input  logic [wis_pkg::WORD_W-1:0]  in_word_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wis_pkg::WORD_W-1:0]  out_word_out,
  output logic                        out_match_found,
  output logic [wis_pkg::IDX_W-1:0]   out_match_index,
  output logic [wis_pkg::STAT_W-1:0]  out_status,
  output logic [wis_pkg::FILL_W-1:0]  out_fill_count
);

  localparam int AW = $clog2(DEPTH);

  logic                  out_valid_r, out_valid_nxt;
  wis_pkg::res_t         res_r;
  wis_pkg::res_t         res;
  logic                  res_load;
  logic                  out_free;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;

  assign out_free = !out_valid_r || !out_stall;

  wis_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_word_in   (in_word_in),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  wis_mem #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word_out    = res_r.word_out;
  assign out_match_found = res_r.match_found;
  assign out_match_index = res_r.match_index;
  assign out_status      = res_r.status;
  assign out_fill_count  = res_r.fill_count;

endmodule

### rtl/wis_checker.sv
// Port-level checker for the word stack and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wis_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [wis_pkg::WORD_W-1:0]  out_word_out,
  input logic                        out_match_found,
  input logic [wis_pkg::IDX_W-1:0]   out_match_index,
  input logic [wis_pkg::STAT_W-1:0]  out_status
);

  // No result item is offered in the cycle after reset.
  `WIS_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)
  // A stalled result item stays offered.
  `WIS_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
  // A refused or out-of-range operation returns no word.
  `WIS_ASSERT_NOW(a_err_no_word, clk, rst_n, out_valid && out_status != wis_pkg::ST_OK, out_word_out == '0)
  // A search hit always reports success and returns no word.
  `WIS_ASSERT_NOW(a_hit_clean, clk, rst_n, out_valid && out_match_found, out_status == wis_pkg::ST_OK && out_word_out == '0)
  // Without a hit the index reads as zero.
  `WIS_ASSERT_NOW(a_miss_index, clk, rst_n, out_valid && !out_match_found, out_match_index == '0)

endmodule

bind indexed_word_stack_with_search_top wis_checker u_wis_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_word_out    (out_word_out),
  .out_match_found (out_match_found),
  .out_match_index (out_match_index),
  .out_status      (out_status)
);
